@@ rtl/core/sqmm_pkg.sv @@
// ----------------------------------------------------------------------------
// sqmm_pkg
// Shared codes and controller/datapath interface types for the square
// matrix multiply block.
// ----------------------------------------------------------------------------
package sqmm_pkg;

  localparam logic [1:0] CMD_WRITE_A = 2'd0;
  localparam logic [1:0] CMD_WRITE_B = 2'd1;
  localparam logic [1:0] CMD_COMPUTE = 2'd2;

  localparam int CFG_WIDTH  = 5;
  localparam logic [CFG_WIDTH-1:0] SIZE_RESET = 5'd16;

  localparam int CMD_WIDTH  = 2;
  localparam int IDX_WIDTH  = 4;
  localparam int PORT_WIDTH = 32;

  // commands from controller to datapath
  typedef struct packed {
    logic wr_a;
    logic wr_b;
    logic start;
    logic issue;
    logic out_load;
  } sqmm_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic rd_busy;
    logic mul_busy;
  } sqmm_stat_t;

endpackage

@@ rtl/core/square_matrix_multiply.sv @@
// ----------------------------------------------------------------------------
// square_matrix_multiply
// Integer matrix multiply-accumulate, one output element per compute request.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_stall): cmd selects write A, write B or compute.
// A write request stores value at (row, col); it is dropped if either index
// is out of range. A compute request returns value plus the dot product of
// row A and column B over min(matrix_size, MAX_N) terms, wrapped to 32 bits;
// an out-of-range index gives no terms. The terms run through one shared
// multiplier, one term per cycle, fed by a registered read of each store,
// then a two-stage drain (multiply register, accumulate) before the result
// register loads; with no terms the compute goes straight to that load.
// The input stalls for the whole compute and takes the next request the
// cycle after the result loads.
// Output channel (out_valid/out_stall): the result register holds while the
// receiver stalls; new write requests are taken meanwhile, and a following
// compute waits in its last step until the register is free.
// cfg_we writes matrix_size; write it only while no compute is in flight.
// Reset (rst_n low, synchronous) clears control state and sets matrix_size
// to 16. Store contents are not cleared; read only written entries.
// ----------------------------------------------------------------------------
module square_matrix_multiply
  import sqmm_pkg::*;
#(
  parameter int MAX_N      = 16,
  parameter int DATA_WIDTH = 32
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [CFG_WIDTH-1:0]         cfg_wdata,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [CMD_WIDTH-1:0]         in_cmd,
  input  logic [IDX_WIDTH-1:0]         in_row,
  input  logic [IDX_WIDTH-1:0]         in_col,
  input  logic signed [PORT_WIDTH-1:0] in_value,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic signed [PORT_WIDTH-1:0] out_product_element
);

  localparam int IW = (MAX_N > 1) ? $clog2(MAX_N) : 1;

  sqmm_cmd_t             cmd;
  sqmm_stat_t            stat;
  logic [IW-1:0]         k_idx;
  logic [PORT_WIDTH-1:0] result;

  sqmm_ctrl #(
    .MAX_N (MAX_N)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_cmd    (in_cmd),
    .in_row    (in_row),
    .in_col    (in_col),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd),
    .k_idx     (k_idx)
  );

  sqmm_datapath #(
    .MAX_N      (MAX_N),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_datapath (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .k_idx    (k_idx),
    .in_row   (in_row),
    .in_col   (in_col),
    .in_value (in_value),
    .stat     (stat),
    .result   (result)
  );

  assign out_product_element = $signed(result);

endmodule

@@ rtl/core/sqmm_datapath.sv @@
// ----------------------------------------------------------------------------
// sqmm_datapath
// A and B element stores, read address generation, multiplier stage,
// accumulator and result register.
// ----------------------------------------------------------------------------
module sqmm_datapath
  import sqmm_pkg::*;
#(
  parameter int MAX_N      = 16,
  parameter int DATA_WIDTH = 32
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  sqmm_cmd_t                    cmd,
  input  logic [((MAX_N > 1) ? $clog2(MAX_N) : 1)-1:0] k_idx,
  input  logic [IDX_WIDTH-1:0]         in_row,
  input  logic [IDX_WIDTH-1:0]         in_col,
  input  logic signed [PORT_WIDTH-1:0] in_value,
  output sqmm_stat_t                   stat,
  output logic [PORT_WIDTH-1:0]        result
);

  // only the low bits that reach the result are ever kept
  localparam int OW    = (DATA_WIDTH < PORT_WIDTH) ? DATA_WIDTH : PORT_WIDTH;
  localparam int DEPTH = MAX_N * MAX_N;
  localparam int AW    = (MAX_N > 1) ? $clog2(DEPTH) : 1;
  localparam int IW    = (MAX_N > 1) ? $clog2(MAX_N) : 1;

  logic [OW-1:0] a_mem [DEPTH];
  logic [OW-1:0] b_mem [DEPTH];

  logic [IDX_WIDTH-1:0] row_r;
  logic [IDX_WIDTH-1:0] col_r;
  logic [OW-1:0]        a_rd_r;
  logic [OW-1:0]        b_rd_r;
  logic [OW-1:0]        prod_r;
  logic [OW-1:0]        acc_r;
  logic [OW-1:0]        out_data_r;
  logic                 rd_v_r;
  logic                 mul_v_r;

  logic [AW-1:0]        wr_addr;
  logic [AW-1:0]        a_addr;
  logic [AW-1:0]        b_addr;
  logic [2*OW-1:0]      prod_full;
  logic [IW-1:0]        k_unused_chk;

  assign k_unused_chk = k_idx;
  assign wr_addr   = AW'(in_row) * AW'(MAX_N) + AW'(in_col);
  assign a_addr    = AW'(row_r) * AW'(MAX_N) + AW'(k_unused_chk);
  assign b_addr    = AW'(k_unused_chk) * AW'(MAX_N) + AW'(col_r);
  assign prod_full = a_rd_r * b_rd_r;

  always_ff @(posedge clk) begin
    if (cmd.wr_a) begin
      a_mem[wr_addr] <= in_value[OW-1:0];
    end
    a_rd_r <= a_mem[a_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_b) begin
      b_mem[wr_addr] <= in_value[OW-1:0];
    end
    b_rd_r <= b_mem[b_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_v_r  <= 1'b0;
      mul_v_r <= 1'b0;
    end else begin
      rd_v_r  <= cmd.issue;
      mul_v_r <= rd_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      row_r <= in_row;
      col_r <= in_col;
    end
    if (rd_v_r) begin
      prod_r <= prod_full[OW-1:0];
    end
    // start and accumulate never overlap: the pipe is empty at start
    if (cmd.start) begin
      acc_r <= in_value[OW-1:0];
    end else if (mul_v_r) begin
      acc_r <= acc_r + prod_r;
    end
    if (cmd.out_load) begin
      out_data_r <= acc_r;
    end
  end

  assign stat.rd_busy  = rd_v_r;
  assign stat.mul_busy = mul_v_r;
  assign result        = PORT_WIDTH'(out_data_r);

endmodule

@@ rtl/core/sqmm_ctrl.sv @@
// ----------------------------------------------------------------------------
// sqmm_ctrl
// Request decode, size register, term sequencer and result handshake.
// ----------------------------------------------------------------------------
module sqmm_ctrl
  import sqmm_pkg::*;
#(
  parameter int MAX_N = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_WIDTH-1:0]  cfg_wdata,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [CMD_WIDTH-1:0]  in_cmd,
  input  logic [IDX_WIDTH-1:0]  in_row,
  input  logic [IDX_WIDTH-1:0]  in_col,
  output logic                  out_valid,
  input  logic                  out_stall,
  input  sqmm_stat_t            stat,
  output sqmm_cmd_t             cmd,
  output logic [((MAX_N > 1) ? $clog2(MAX_N) : 1)-1:0] k_idx
);

  localparam int IW = (MAX_N > 1) ? $clog2(MAX_N) : 1;
  localparam int KW = $clog2(MAX_N + 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_ISSUE,
    S_FINISH
  } state_t;

  state_t               state_r, state_nxt;
  logic [CFG_WIDTH-1:0] size_r, size_nxt;
  logic [KW-1:0]        n_r, n_nxt;
  logic [IW-1:0]        k_r, k_nxt;
  logic                 out_valid_r, out_valid_nxt;

  logic          accept;
  logic          in_range;
  logic [KW-1:0] eff_n;
  logic          last_term;

  assign in_stall  = (state_r != S_IDLE);
  assign accept    = in_valid && !in_stall;
  assign in_range  = (32'(in_row) < 32'(MAX_N)) && (32'(in_col) < 32'(MAX_N));
  assign last_term = (KW'(k_r) == n_r - KW'(1));

  always_comb begin
    if (!in_range) begin
      // row or col out of range: no terms are issued
      eff_n = '0;
    end else if (32'(size_r) > 32'(MAX_N)) begin
      eff_n = KW'(MAX_N);
    end else begin
      eff_n = KW'(size_r);
    end
  end

  always_comb begin
    state_nxt     = state_r;
    size_nxt      = cfg_we ? cfg_wdata : size_r;
    n_nxt         = n_r;
    k_nxt         = k_r;
    out_valid_nxt = out_valid_r;
    cmd           = '0;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          cmd.wr_a = (in_cmd == CMD_WRITE_A) && in_range;
          cmd.wr_b = (in_cmd == CMD_WRITE_B) && in_range;
          if (in_cmd == CMD_COMPUTE) begin
            cmd.start = 1'b1;
            n_nxt     = eff_n;
            k_nxt     = '0;
            state_nxt = (eff_n == '0) ? S_FINISH : S_ISSUE;
          end
        end
      end
      S_ISSUE: begin
        cmd.issue = 1'b1;
        k_nxt     = k_r + IW'(1);
        if (last_term) begin
          state_nxt = S_FINISH;
        end
      end
      S_FINISH: begin
        // wait for the pipe to drain and the result slot to free up
        if (!stat.rd_busy && !stat.mul_busy && (!out_valid_r || !out_stall)) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      size_r      <= SIZE_RESET;
      n_r         <= '0;
      k_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      size_r      <= size_nxt;
      n_r         <= n_nxt;
      k_r         <= k_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign k_idx     = k_r;

endmodule
